// ===== rtl/atp_pkg.sv =====
// Package: shared types, constants and widths for the AT response line parser.
`timescale 1ns / 1ps

package atp_pkg;

  localparam int MAX_LINES  = 8;
  localparam int LINE_CHARS = 64;

  localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W   = $clog2(MAX_LINES + 1);
  localparam int COL_W   = $clog2(LINE_CHARS);
  localparam int ADDR_W  = $clog2(MAX_LINES * LINE_CHARS);
  localparam int DEPTH   = MAX_LINES * LINE_CHARS;

  localparam int BYTE_W  = 8;
  localparam int RLINE_W = 3;
  localparam int RCOL_W  = 6;
  localparam int STAT_W  = 2;
  localparam int LCNT_W  = 4;

  localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K    = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
  localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_MORE = 2'd0,
    STAT_END  = 2'd1,
    STAT_ERR  = 2'd2
  } stat_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_LF1      = 5'd1,
    ST_FIRST    = 5'd2,
    ST_OK_K     = 5'd3,
    ST_OK_CR    = 5'd4,
    ST_END_LF   = 5'd5,
    ST_ER_R1    = 5'd7,
    ST_ER_R2    = 5'd8,
    ST_ER_O     = 5'd9,
    ST_ER_R3    = 5'd10,
    ST_ER_CR    = 5'd11,
    ST_PLUS     = 5'd12,
    ST_TEXT     = 5'd13,
    ST_TEXT_LF  = 5'd14,
    ST_NEXT     = 5'd15,
    ST_BLANK_LF = 5'd16,
    ST_FINAL    = 5'd17
  } parse_state_e;

  // Byte class flags decoded by the front end.
  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_plus;
    logic is_o;
    logic is_k;
    logic is_e;
    logic is_r;
  } byte_cls_t;

  typedef struct packed {
    op_e                op;
    logic [BYTE_W-1:0]  rx_byte;
    logic [RLINE_W-1:0] read_line;
    logic [RCOL_W-1:0]  read_column;
    byte_cls_t          cls;
  } cmd_t;

  // Actions the parser takes for one byte.
  typedef struct packed {
    logic fail;
    logic clear;
    logic put;
    logic line_end;
    logic complete;
    logic set_ok;
    logic clr_ok;
  } act_t;

endpackage

// ===== rtl/atp_front.sv =====
// Front end: decodes the incoming transaction and the byte class.
`timescale 1ns / 1ps

module atp_front import atp_pkg::*; (
  input  logic               operation_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [RLINE_W-1:0] read_line_i,
  input  logic [RCOL_W-1:0]  read_column_i,
  output cmd_t               cmd_o
);

  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = op_e'(operation_i);
    cmd_o.rx_byte     = rx_byte_i;
    cmd_o.read_line   = read_line_i;
    cmd_o.read_column = read_column_i;
    cmd_o.cls.is_cr   = (rx_byte_i == CH_CR);
    cmd_o.cls.is_lf   = (rx_byte_i == CH_LF);
    cmd_o.cls.is_plus = (rx_byte_i == CH_PLUS);
    cmd_o.cls.is_o    = (rx_byte_i == CH_O);
    cmd_o.cls.is_k    = (rx_byte_i == CH_K);
    cmd_o.cls.is_e    = (rx_byte_i == CH_E);
    cmd_o.cls.is_r    = (rx_byte_i == CH_R);
  end

endmodule

// ===== rtl/atp_fifo.sv =====
// Two-entry command queue between front end and parser back end.
`timescale 1ns / 1ps

module atp_fifo import atp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with full count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

endmodule

// ===== rtl/atp_back.sv =====
// Back end: parser state machine, line store and registered result stage.
`timescale 1ns / 1ps

module atp_back import atp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  cmd_t               cmd_i,
  input  logic               cmd_avail_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic               ok_seen_o,
  output logic [LCNT_W-1:0]  lines_stored_o,
  output logic [BYTE_W-1:0]  read_char_o
);

  parse_state_e      state_q, state_d;
  logic              plus_mode_q;
  logic [COL_W-1:0]  len_q [MAX_LINES];
  logic [CNT_W-1:0]  cur_line_q, cur_line_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              ok_q, ok_d;

  logic [BYTE_W-1:0] store [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic              out_valid_q;
  stat_e             status_q, status_d;
  logic              ok_out_q;
  logic [CNT_W-1:0]  lines_out_q;
  logic              hit_q, hit_d;

  act_t              act;
  logic              feed;
  logic              eol;
  logic              line_room;
  logic              do_write;
  logic              do_line_end;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [LINE_W-1:0] rd_idx;
  logic [LINE_W-1:0] wr_idx;

  assign pop_o = cmd_avail_i && (!out_valid_q || !out_stall_i);
  assign feed  = pop_o && (cmd_i.op == OP_FEED);
  assign eol   = cmd_i.cls.is_cr || cmd_i.cls.is_lf;

  assign line_room   = (32'(cur_line_q) < MAX_LINES);
  assign wr_idx      = LINE_W'(cur_line_q);
  assign do_write    = feed && act.put && line_room && (32'(cur_col_q) < LINE_CHARS - 1);
  assign do_line_end = feed && act.line_end && line_room;
  assign waddr       = ADDR_W'(wr_idx) * ADDR_W'(LINE_CHARS) + ADDR_W'(cur_col_q);

  assign rd_idx = LINE_W'(cmd_i.read_line);
  assign raddr  = ADDR_W'(rd_idx) * ADDR_W'(LINE_CHARS) + ADDR_W'(cmd_i.read_column);
  assign hit_d  = (cmd_i.op == OP_READ) && (32'(cmd_i.read_line) < MAX_LINES) &&
                  (32'(cmd_i.read_column) < 32'(len_q[rd_idx]));

  // Parser actions for the byte at the head of the queue.
  always_comb begin
    act      = '0;
    status_d = STAT_MORE;
    if (cmd_i.op == OP_FEED) begin
      case (state_q)
        ST_IDLE:     act.clear = cmd_i.cls.is_cr;
        ST_LF1:      act.fail  = !cmd_i.cls.is_lf;
        ST_FIRST: begin
          if (cmd_i.cls.is_o || cmd_i.cls.is_e || (cmd_i.cls.is_plus && plus_mode_q)) begin
            act = '0;
          end else if (!eol && !plus_mode_q) begin
            act.put = 1'b1;
          end else begin
            act.fail = 1'b1;
          end
        end
        ST_OK_K: begin
          act.fail   = !cmd_i.cls.is_k;
          act.set_ok = cmd_i.cls.is_k;
        end
        ST_OK_CR, ST_ER_CR: act.fail = !cmd_i.cls.is_cr;
        ST_END_LF: begin
          act.fail     = !cmd_i.cls.is_lf;
          act.complete = cmd_i.cls.is_lf;
        end
        ST_ER_R1, ST_ER_R2: act.fail = !cmd_i.cls.is_r;
        ST_ER_O:            act.fail = !cmd_i.cls.is_o;
        ST_ER_R3: begin
          act.fail   = !cmd_i.cls.is_r;
          act.clr_ok = cmd_i.cls.is_r;
        end
        ST_PLUS: begin
          act.fail = eol;
          act.put  = !eol;
        end
        ST_TEXT: begin
          act.put      = !eol;
          act.line_end = cmd_i.cls.is_cr;
          act.fail     = cmd_i.cls.is_lf;
        end
        ST_TEXT_LF, ST_BLANK_LF: act.fail = !cmd_i.cls.is_lf;
        ST_NEXT:  act.fail = !((cmd_i.cls.is_plus && plus_mode_q) || cmd_i.cls.is_cr);
        ST_FINAL: act.fail = !(cmd_i.cls.is_e || cmd_i.cls.is_o);
        default:  act = '0;
      endcase
      if (act.fail) begin
        status_d = STAT_ERR;
      end else if (act.complete) begin
        status_d = STAT_END;
      end
    end
  end

  // Next parse state.
  always_comb begin
    state_d = state_q;
    if (feed) begin
      case (state_q)
        ST_IDLE:  if (cmd_i.cls.is_cr) state_d = ST_LF1;
        ST_LF1:   state_d = ST_FIRST;
        ST_FIRST: begin
          if (cmd_i.cls.is_o) begin
            state_d = ST_OK_K;
          end else if (cmd_i.cls.is_e) begin
            state_d = ST_ER_R1;
          end else if (cmd_i.cls.is_plus && plus_mode_q) begin
            state_d = ST_PLUS;
          end else begin
            state_d = ST_TEXT;
          end
        end
        ST_OK_K:     state_d = ST_OK_CR;
        ST_OK_CR:    state_d = ST_END_LF;
        ST_ER_CR:    state_d = ST_END_LF;
        ST_END_LF:   state_d = ST_IDLE;
        ST_ER_R1:    state_d = ST_ER_R2;
        ST_ER_R2:    state_d = ST_ER_O;
        ST_ER_O:     state_d = ST_ER_R3;
        ST_ER_R3:    state_d = ST_ER_CR;
        ST_PLUS:     state_d = ST_TEXT;
        ST_TEXT:     if (cmd_i.cls.is_cr) state_d = ST_TEXT_LF;
        ST_TEXT_LF:  state_d = ST_NEXT;
        ST_NEXT: begin
          if (cmd_i.cls.is_plus && plus_mode_q) begin
            state_d = ST_PLUS;
          end else begin
            state_d = ST_BLANK_LF;
          end
        end
        ST_BLANK_LF: state_d = ST_FINAL;
        ST_FINAL:    state_d = cmd_i.cls.is_e ? ST_ER_R1 : ST_OK_K;
        default:     state_d = ST_IDLE;
      endcase
      if (act.fail) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Counters and flags after this transaction.
  always_comb begin
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    total_d    = total_q;
    ok_d       = ok_q;
    if (feed) begin
      if (act.set_ok) ok_d = 1'b1;
      if (act.clr_ok) ok_d = 1'b0;
      if (do_write) cur_col_d = cur_col_q + COL_W'(1);
      if (do_line_end) begin
        cur_col_d  = '0;
        cur_line_d = cur_line_q + CNT_W'(1);
        total_d    = total_q + CNT_W'(1);
      end
      if (act.complete || act.fail) begin
        cur_line_d = '0;
        cur_col_d  = '0;
      end
      if (act.clear || act.fail) begin
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plus_mode_q <= 1'b1;
      cur_line_q  <= '0;
      cur_col_q   <= '0;
      total_q     <= '0;
      ok_q        <= 1'b0;
      for (int i = 0; i < MAX_LINES; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        plus_mode_q <= cfg_wdata_i;
      end
      state_q    <= state_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      total_q    <= total_d;
      ok_q       <= ok_d;
      if (feed && (act.clear || act.fail)) begin
        for (int i = 0; i < MAX_LINES; i++) begin
          len_q[i] <= '0;
        end
      end else if (do_line_end) begin
        len_q[wr_idx] <= cur_col_q;
      end
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store[waddr] <= cmd_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= store[raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= STAT_MORE;
      ok_out_q    <= 1'b0;
      lines_out_q <= '0;
      hit_q       <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
      status_q    <= status_d;
      ok_out_q    <= ok_d;
      lines_out_q <= total_d;
      hit_q       <= hit_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign ok_seen_o      = ok_out_q;
  assign lines_stored_o = LCNT_W'(lines_out_q);
  assign read_char_o    = hit_q ? rdata_q : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (feed && act.complete) |=> (state_q == ST_IDLE && cur_line_q == '0))
    else $error("completion did not return parser to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (feed && act.fail) |=> (total_q == '0 && cur_line_q == '0 &&
                                           cur_col_q == '0))
    else $error("format error did not clear the parser");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (32'(total_q) <= MAX_LINES) && (32'(cur_line_q) <= MAX_LINES))
    else $error("line counters past store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop_o && cmd_i.op == OP_READ) |=> (status_q == STAT_MORE))
    else $error("read transaction produced a parse status");

endmodule

// ===== rtl/at_response_line_parser.sv =====
// Top level: AT response line parser with decoupled decode and parse stages.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   operation_i = 0 feeds rx_byte_i to the parser, 1 reads one character of
//   the line store at read_line_i / read_column_i.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   input transaction, in order: status, ok_seen, lines_stored, read_char.
//   Configuration: cfg_we_i writes cfg_wdata_i into the plus-prefixed mode bit
//   (reset value 1). Write it only while no transaction is in flight.
// Timing: an accepted input is first registered in the command queue; when
//   the queue head is popped, the parse result and line store read data are
//   registered in the result stage.
// Throughput: one transaction per cycle unless out_stall_i holds the result;
//   the parse state machine and the line store write handle one byte per pop.
// Reset: parser idle (waiting for CR), line lengths and counters zero,
//   ok flag zero, mode plus-prefixed. Line store contents are not cleared;
//   reads are gated by the recorded line length. No clearing pass is needed.
// Stall: when out_stall_i holds the result, the parse stage stops popping and
//   the two-entry queue absorbs up to two more transactions before in_stall_o
//   rises.
module at_response_line_parser import atp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [RLINE_W-1:0] read_line_i,
  input  logic [RCOL_W-1:0]  read_column_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic               ok_seen_o,
  output logic [LCNT_W-1:0]  lines_stored_o,
  output logic [BYTE_W-1:0]  read_char_o
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;
  logic q_push;
  logic q_pop;

  // Decode: byte class flags computed before queuing.
  atp_front u_front (
    .operation_i   (operation_i),
    .rx_byte_i     (rx_byte_i),
    .read_line_i   (read_line_i),
    .read_column_i (read_column_i),
    .cmd_o         (front_cmd)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  atp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_cmd),
    .pop_i       (q_pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Parse stage: state machine, line store, result register.
  atp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (head_cmd),
    .cmd_avail_i    (!q_empty),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .ok_seen_o      (ok_seen_o),
    .lines_stored_o (lines_stored_o),
    .read_char_o    (read_char_o)
  );

endmodule

// ===== tb/tb_at_response_line_parser.sv =====
// Self-checking testbench for the AT response line parser: directed table, then random responses.
`timescale 1ns / 1ps

module tb_at_response_line_parser;
  import atp_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the input queue
  localparam int DRAIN_CYCLES = 8;    // settling time after the last owed result
  localparam int STUCK_LIMIT  = 2000; // cycles without any transaction before giving up
  localparam int MAX_REPORTS  = 10;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    stat_e              status;
    logic               ok_seen;
    logic [LCNT_W-1:0]  lines;
    logic [BYTE_W-1:0]  ch;
  } result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    op_e                op;
    logic [BYTE_W-1:0]  data;
    logic [RLINE_W-1:0] line;
    logic [RCOL_W-1:0]  col;
    logic               typed;
    result_t            want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic               cfg_wdata   = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               operation   = 1'b0;
  logic [BYTE_W-1:0]  rx_byte     = '0;
  logic [RLINE_W-1:0] read_line   = '0;
  logic [RCOL_W-1:0]  read_column = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [STAT_W-1:0]  status;
  logic               ok_seen;
  logic [LCNT_W-1:0]  lines_stored;
  logic [BYTE_W-1:0]  read_char;

  always #1 clk = ~clk;

  at_response_line_parser i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .rx_byte_i      (rx_byte),
    .read_line_i    (read_line),
    .read_column_i  (read_column),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .ok_seen_o      (ok_seen),
    .lines_stored_o (lines_stored),
    .read_char_o    (read_char)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: mode bit, state machine, line store and counters.
  // Starts in the reset state; updated once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic               plus_mode = 1'b1;
  parse_state_e       ps        = ST_IDLE;
  logic [BYTE_W-1:0]  line_mem [DEPTH];
  logic [6:0]         line_len [MAX_LINES];
  logic [3:0]         cur_line  = '0;
  logic [6:0]         cur_col   = '0;
  logic [LCNT_W-1:0]  line_cnt  = '0;
  logic               ok_bit    = 1'b0;

  result_t            expected_q [$];   // results still owed by the DUT, oldest first
  dir_row_t           dir_rows [$];

  // Run bookkeeping.
  logic quiet    = 1'b0;  // no idling on either side while set
  logic hold_req = 1'b0;  // sender asks the receiver for one long hold-off
  int   mismatches = 0;
  int   item_cnt   = 0;   // input transactions that the parser does not ignore
  int   read_cnt   = 0;
  int   done_cnt   = 0;
  int   ferr_cnt   = 0;
  int   full_cnt   = 0;   // responses that filled every line slot

  function automatic void clear_lines();
    for (int i = 0; i < MAX_LINES; i++) line_len[i] = '0;
    line_cnt = '0;
  endfunction

  function automatic stat_e parse_fail();
    ps       = ST_IDLE;
    cur_line = '0;
    cur_col  = '0;
    clear_lines();
    return STAT_ERR;
  endfunction

  // Store one payload character; the last column and lines past the store are dropped.
  function automatic void keep_char(logic [BYTE_W-1:0] c);
    if (cur_line < MAX_LINES && cur_col < LINE_CHARS - 1) begin
      line_mem[cur_line * LINE_CHARS + cur_col] = c;
      cur_col++;
    end
  endfunction

  function automatic stat_e parse_byte(logic [BYTE_W-1:0] c);
    logic eol;
    eol = (c == CH_CR) || (c == CH_LF);
    case (ps)
      ST_IDLE: begin
        // anything but CR is line noise; CR opens a response and clears the line lengths
        if (c == CH_CR) begin
          clear_lines();
          ps = ST_LF1;
        end
      end
      ST_LF1: begin
        if (c != CH_LF) return parse_fail();
        ps = ST_FIRST;
      end
      ST_FIRST: begin
        if (c == CH_O) ps = ST_OK_K;
        else if (c == CH_E) ps = ST_ER_R1;
        else if (c == CH_PLUS && plus_mode) ps = ST_PLUS;
        else if (!eol && !plus_mode) begin
          ps = ST_TEXT;
          keep_char(c);
        end else return parse_fail();
      end
      ST_OK_K: begin
        if (c != CH_K) return parse_fail();
        ok_bit = 1'b1;
        ps     = ST_OK_CR;
      end
      ST_OK_CR, ST_ER_CR: begin
        if (c != CH_CR) return parse_fail();
        ps = ST_END_LF;
      end
      ST_END_LF: begin
        if (c != CH_LF) return parse_fail();
        ps       = ST_IDLE;
        cur_line = '0;
        cur_col  = '0;
        return STAT_END;
      end
      ST_ER_R1: begin
        if (c != CH_R) return parse_fail();
        ps = ST_ER_R2;
      end
      ST_ER_R2: begin
        if (c != CH_R) return parse_fail();
        ps = ST_ER_O;
      end
      ST_ER_O: begin
        if (c != CH_O) return parse_fail();
        ps = ST_ER_R3;
      end
      ST_ER_R3: begin
        if (c != CH_R) return parse_fail();
        ok_bit = 1'b0;
        ps     = ST_ER_CR;
      end
      ST_PLUS: begin
        if (eol) return parse_fail();
        ps = ST_TEXT;
        keep_char(c);
      end
      ST_TEXT: begin
        if (!eol) keep_char(c);
        else if (c == CH_CR) begin
          ps = ST_TEXT_LF;
          // lines past the store depth are parsed but neither kept nor counted
          if (cur_line < MAX_LINES) begin
            line_len[cur_line] = cur_col;
            cur_col  = '0;
            cur_line++;
            line_cnt++;
          end
        end else return parse_fail();
      end
      ST_TEXT_LF: begin
        if (c != CH_LF) return parse_fail();
        ps = ST_NEXT;
      end
      ST_NEXT: begin
        // only '+' (plus mode) or the blank line may follow a payload line
        if (c == CH_PLUS && plus_mode) ps = ST_PLUS;
        else if (c == CH_CR) ps = ST_BLANK_LF;
        else return parse_fail();
      end
      ST_BLANK_LF: begin
        if (c != CH_LF) return parse_fail();
        ps = ST_FINAL;
      end
      ST_FINAL: begin
        if (c == CH_E) ps = ST_ER_R1;
        else if (c == CH_O) ps = ST_OK_K;
        else return parse_fail();
      end
      default: ps = ST_IDLE;
    endcase
    return STAT_MORE;
  endfunction

  function automatic result_t predict_result(op_e op, logic [BYTE_W-1:0] data,
                                             logic [RLINE_W-1:0] line,
                                             logic [RCOL_W-1:0] col);
    result_t r;
    r.status = STAT_MORE;
    r.ch     = '0;
    if (op == OP_FEED) r.status = parse_byte(data);
    else if (col < line_len[line]) r.ch = line_mem[line * LINE_CHARS + col];
    r.ok_seen = ok_bit;
    r.lines   = line_cnt;
    return r;
  endfunction

  function automatic dir_row_t table_entry(op_e op, logic [BYTE_W-1:0] data,
                                           logic [RLINE_W-1:0] line,
                                           logic [RCOL_W-1:0] col, logic typed,
                                           stat_e st, logic ok, logic [LCNT_W-1:0] n,
                                           logic [BYTE_W-1:0] ch);
    dir_row_t e;
    e.op           = op;
    e.data         = data;
    e.line         = line;
    e.col          = col;
    e.typed        = typed;
    e.want.status  = st;
    e.want.ok_seen = ok;
    e.want.lines   = n;
    e.want.ch      = ch;
    return e;
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(255));
    while (c == CH_CR || c == CH_LF) c = BYTE_W'($urandom_range(255));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Payload changes only at the falling edge; a transaction is
  // taken at the rising edge where valid is high and in_stall is low. On
  // return valid is still high, so the caller either offers the next
  // transaction or calls idle_bus before anything else.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_e op, logic [BYTE_W-1:0] data, logic [RLINE_W-1:0] line,
                           logic [RCOL_W-1:0] col, logic typed, result_t want);
    result_t r;
    logic    ignored;
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    operation   <= op;
    rx_byte     <= data;
    read_line   <= line;
    read_column <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ignored = (op == OP_FEED) && (ps == ST_IDLE) && (data != CH_CR);
    r = predict_result(op, data, line, col);
    expected_q.push_back(typed ? want : r);
    if (!ignored) item_cnt++;
    if (op == OP_READ) read_cnt++;
    if (r.status == STAT_END) begin
      done_cnt++;
      if (r.lines == MAX_LINES) full_cnt++;
    end
    if (r.status == STAT_ERR) ferr_cnt++;
  endtask

  // Feeds carry random read fields and reads a random byte, so every input bit toggles.
  task automatic send_feed(logic [BYTE_W-1:0] c);
    send_item(OP_FEED, c, RLINE_W'($urandom_range(7)), RCOL_W'($urandom_range(63)),
              1'b0, '0);
  endtask

  task automatic send_read_rand();
    send_item(OP_READ, BYTE_W'($urandom_range(255)),
              RLINE_W'(($urandom_range(2) != 0) ? $urandom_range(3) : $urandom_range(7)),
              RCOL_W'(($urandom_range(3) != 0) ? $urandom_range(11) : $urandom_range(63)),
              1'b0, '0);
  endtask

  task automatic idle_bus();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sender pause: wait for every owed result, then let the pipeline settle.
  task automatic wait_drained();
    idle_bus();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mode writes only happen with nothing in flight.
  task automatic write_mode(logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    plus_mode = m;
  endtask

  // One response: CR LF, payload lines, blank line when lines exist, OK or
  // ERROR, CR LF. Mostly well formed; sometimes noise in front, one byte
  // corrupted, or cut short so the next response lands mid-parse.
  task automatic send_response();
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] c;
    int                n_lines;
    int                len;
    int                cut;
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = BYTE_W'($urandom_range(255));
        if (c == CH_CR) c = 8'h00;
        seq.push_back(c);
      end
    end
    seq.push_back(CH_CR);
    seq.push_back(CH_LF);
    if (plus_mode) n_lines = ($urandom_range(9) == 0) ? $urandom_range(8, 11) : $urandom_range(3);
    else n_lines = ($urandom_range(7) == 0) ? 2 : $urandom_range(1); // raw: a second line is broken
    for (int i = 0; i < n_lines; i++) begin
      len = ($urandom_range(14) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      if (plus_mode) seq.push_back(CH_PLUS);
      for (int j = 0; j < len; j++) begin
        c = text_byte();
        // a raw first line must not look like the start of OK or ERROR
        if (!plus_mode && i == 0 && j == 0) begin
          while (c == CH_O || c == CH_E) c = text_byte();
        end
        seq.push_back(c);
      end
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end
    if (n_lines > 0) begin
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end
    if ($urandom_range(1) == 1) begin
      seq.push_back(CH_O);
      seq.push_back(CH_K);
    end else begin
      seq.push_back(CH_E);
      seq.push_back(CH_R);
      seq.push_back(CH_R);
      seq.push_back(CH_O);
      seq.push_back(CH_R);
    end
    seq.push_back(CH_CR);
    seq.push_back(CH_LF);
    if ($urandom_range(7) == 0) seq[$urandom_range(seq.size() - 1)] = BYTE_W'($urandom_range(255));
    cut = ($urandom_range(15) == 0) ? $urandom_range(1, seq.size()) : seq.size();
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(9) == 0) send_read_rand();
      send_feed(seq[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, a quiet stretch, and one long hold-off
  // counted here while the sender keeps offering transactions.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted result against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.status  = stat_e'(status);
      got.ok_seen = ok_seen;
      got.lines   = lines_stored;
      got.ch      = read_char;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result st=%0d ok=%0d lines=%0d ch=%02h", $realtime,
                   status, ok_seen, lines_stored, read_char);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.ok_seen !== want.ok_seen ||
            got.lines !== want.lines || got.ch !== want.ch) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp st=%0d ok=%0d lines=%0d ch=%02h got st=%0d ok=%0d lines=%0d ch=%02h",
                     $realtime, want.status, want.ok_seen, want.lines, want.ch,
                     status, ok_seen, lines_stored, read_char);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel.
  always @(posedge clk) begin : watchdog
    int stuck;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results owed",
                 stuck, expected_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int  start;
    logic held;
    logic paused;
    held   = 1'b0;
    paused = 1'b0;
    for (int i = 0; i < MAX_LINES; i++) line_len[i] = '0;

    // Directed table, in plus mode straight out of reset. Typed rows: reset
    // state, ignored line noise, and a bare LF where the first line must start.
    dir_rows.push_back(table_entry(OP_READ, 8'h00, 3'd7, 6'd63, 1'b1, STAT_MORE, 0, 0, 8'h00));
    dir_rows.push_back(table_entry(OP_FEED, 8'hFF, 3'd7, 6'd63, 1'b1, STAT_MORE, 0, 0, 8'h00));
    dir_rows.push_back(table_entry(OP_FEED, 8'h00, 3'd0, 6'd0,  1'b1, STAT_MORE, 0, 0, 8'h00));
    dir_rows.push_back(table_entry(OP_FEED, CH_CR, 3'd0, 6'd0,  1'b1, STAT_MORE, 0, 0, 8'h00));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF, 3'd0, 6'd0,  1'b1, STAT_MORE, 0, 0, 8'h00));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF, 3'd0, 6'd0,  1'b1, STAT_ERR,  0, 0, 8'h00));
    // one payload line with extreme bytes, then ERROR entered with a leading E
    dir_rows.push_back(table_entry(OP_FEED, CH_CR,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_PLUS, 3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, 8'h80,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, 8'h7F,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_CR,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_CR,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_E,    3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_R,    3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_R,    3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_O,    3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_R,    3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_CR,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_FEED, CH_LF,   3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    // read back the kept line, including one column past its end
    dir_rows.push_back(table_entry(OP_READ, 8'hFF, 3'd0, 6'd0, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_READ, 8'h00, 3'd0, 6'd1, 1'b0, STAT_MORE, 0, 0, 0));
    dir_rows.push_back(table_entry(OP_READ, 8'h00, 3'd0, 6'd2, 1'b0, STAT_MORE, 0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].line, dir_rows[i].col,
                dir_rows[i].typed, dir_rows[i].want);

    // Random phases alternate the mode, starting with an explicit write of
    // plus mode. Phase 2 carries the long receiver hold-off, phase 3 runs
    // with no idling, phase 4 has a mid-phase sender pause.
    for (int p = 0; p < PHASES; p++) begin
      write_mode((p % 2 == 0) ? 1'b1 : 1'b0);
      quiet = (p == 3);
      start = item_cnt;
      while (item_cnt - start < ITEM_TARGET / PHASES) begin
        if (p == 2 && !held && item_cnt - start > 40) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (p == 4 && !paused && item_cnt - start > 100) begin
          wait_drained();
          paused = 1'b1;
        end
        send_response();
        repeat ($urandom_range(3)) send_read_rand();
      end
    end
    quiet = 1'b0;

    idle_bus();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d parsed transactions (%0d reads), %0d complete responses (%0d with a full store), %0d format errors",
             item_cnt, read_cnt, done_cnt, full_cnt, ferr_cnt);
    $display("Both line modes, long receiver hold-off, sender pause and a no-idle stretch; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== at_response_line_parser.f =====
rtl/atp_pkg.sv
rtl/atp_front.sv
rtl/atp_fifo.sv
rtl/atp_back.sv
rtl/at_response_line_parser.sv
tb/tb_at_response_line_parser.sv
